### hdl/gmhb_pkg.sv
// shared types, codes and helpers for the grid mesh half-edge builder
`default_nettype none

package gmhb_pkg;

  localparam int DIM_W    = 11;
  localparam int DIM_MIN  = 2;
  localparam int TRI_W    = 21;
  localparam int PT_W     = 20;
  localparam int EDGE_W   = 23;
  localparam int SLOT_NUM = 5;
  localparam int SLOT_W   = 3;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam logic KIND_TRI  = 1'b0;
  localparam logic KIND_PAIR = 1'b1;

  localparam logic [SLOT_W-1:0] SLOT_FIRST  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_SECOND = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_DIAG   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_TOP    = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_LEFT   = 3'd4;

  localparam logic [1:0] EDGE_0 = 2'd0;
  localparam logic [1:0] EDGE_1 = 2'd1;
  localparam logic [1:0] EDGE_2 = 2'd2;

  typedef logic [TRI_W-1:0] tri_idx_t;
  typedef logic [PT_W-1:0]  pt_idx_t;

  typedef struct packed {
    logic [SLOT_NUM-1:0] mask;
    tri_idx_t            f;
    tri_idx_t            s;
    tri_idx_t            up;
    tri_idx_t            lf;
    pt_idx_t             p1;
    pt_idx_t             p2;
    pt_idx_t             p3;
    pt_idx_t             p4;
  } bundle_t;

  function automatic logic [EDGE_W-1:0] edge_num(input tri_idx_t t, input logic [1:0] e);
    logic [EDGE_W-1:0] tw;
    tw = EDGE_W'(t);
    return (tw << 1) + tw + EDGE_W'(e);
  endfunction

endpackage

`default_nettype wire

### hdl/gmhb_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module gmhb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/grid_mesh_halfedge_builder.sv
// top level: organized grid triangulator with half-edge twin pairing
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in      | input     | in_valid/in_ready  | point_valid
//   out     | output    | out_valid/out_ready| kind tri_number vertex_a..c edge_a edge_b last
//   cfg     | input     | cfg_we             | cfg_index cfg_data
//
// an item yields n (0..5) results; the single output register moves one result per cycle
// unless out_ready stalls it, and a point waits in the cell stage until the sequencer can take its results
// after the input transfer the first result passes the registers of each stage (cell logic, sequencer, output)
// line buffers sit in two rams read at the input transfer and written back one stage later
// no clearing pass after reset; a config write restarts the frame
`default_nettype none

module grid_mesh_halfedge_builder
  import gmhb_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              point_valid,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   kind,
  output logic [TRI_W-1:0]       tri_number,
  output logic [PT_W-1:0]        vertex_a,
  output logic [PT_W-1:0]        vertex_b,
  output logic [PT_W-1:0]        vertex_c,
  output logic [EDGE_W-1:0]      edge_a,
  output logic [EDGE_W-1:0]      edge_b,
  output logic                   last,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v < DIM_W'(DIM_MIN)) return DIM_W'(DIM_MIN);
    if (int'(v) > hi) return DIM_W'(hi);
    return v;
  endfunction

  logic [DIM_W-1:0] cols;
  logic [DIM_W-1:0] rows;
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  pt_idx_t          pidx;
  logic             accept;
  logic             col_last;
  logic             row_last;

  logic             s1_valid;
  logic             s1_pv;
  logic [CW-1:0]    s1_col;
  logic             s1_cell;
  logic             s1_top;
  logic             s1_left;
  pt_idx_t          s1_pidx;
  logic             s1_frame_end;
  logic             s1_adv;

  tri_idx_t         tri_cnt;
  logic             left_pv;
  logic             upper_left;
  logic             lf_ok;
  tri_idx_t         lf_tri;

  logic             row_q;
  logic [TRI_W:0]   tri_q;
  logic             f_ok;
  logic             s_ok;
  tri_idx_t         s_val;
  logic [SLOT_NUM-1:0] m1;
  pt_idx_t          p1;
  pt_idx_t          p2;
  pt_idx_t          p4;

  bundle_t             s2;
  logic [SLOT_W-1:0]   sel;
  logic [SLOT_NUM-1:0] rest;
  logic                load_out;
  logic                s2_free;

  logic                kind_next;
  tri_idx_t            tri_number_next;
  pt_idx_t             vertex_a_next;
  pt_idx_t             vertex_b_next;
  pt_idx_t             vertex_c_next;
  logic [EDGE_W-1:0]   edge_a_next;
  logic [EDGE_W-1:0]   edge_b_next;

  // input side and counters
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign col_last = (DIM_W+1)'(col) == ({1'b0, cols} - (DIM_W+1)'(1));
  assign row_last = (DIM_W+1)'(row) == ({1'b0, rows} - (DIM_W+1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= DIM_W'(DIM_MIN);
      rows <= DIM_W'(DIM_MIN);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: cols <= clamp_dim(cfg_data, MAX_COLS);
        CFG_ROWS: rows <= clamp_dim(cfg_data, MAX_ROWS);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col  <= '0;
      row  <= '0;
      pidx <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row  <= '0;
          pidx <= '0;
        end else begin
          row  <= row + RW'(1);
          pidx <= pidx + PT_W'(1);
        end
      end else begin
        col  <= col + CW'(1);
        pidx <= pidx + PT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pv        <= point_valid;
      s1_col       <= col;
      s1_cell      <= (row != '0) && (col != '0);
      s1_top       <= row > RW'(1);
      s1_left      <= col > CW'(1);
      s1_pidx      <= pidx;
      s1_frame_end <= col_last && row_last;
    end
  end

  // line buffers: point validity of the row above, second triangle of the cell row above
  gmhb_ram #(
    .WIDTH (1),
    .DEPTH (MAX_COLS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_pv),
    .re    (accept),
    .raddr (col),
    .rdata (row_q)
  );

  gmhb_ram #(
    .WIDTH (TRI_W + 1),
    .DEPTH (MAX_COLS)
  ) u_tri_ram (
    .clk   (clk),
    .we    (s1_adv && s1_cell),
    .waddr (s1_col - CW'(1)),
    .wdata ({s_ok, s_val}),
    .re    (accept),
    .raddr (col - CW'(1)),
    .rdata (tri_q)
  );

  // cell logic
  assign f_ok  = s1_cell && upper_left && row_q && s1_pv;
  assign s_ok  = s1_cell && s1_pv && left_pv && upper_left;
  assign s_val = tri_cnt + TRI_W'(f_ok);

  always_comb begin
    m1              = '0;
    m1[SLOT_FIRST]  = f_ok;
    m1[SLOT_SECOND] = s_ok;
    m1[SLOT_DIAG]   = f_ok && s_ok;
    m1[SLOT_TOP]    = f_ok && s1_top && tri_q[TRI_W];
    m1[SLOT_LEFT]   = s_ok && s1_left && lf_ok;
  end

  assign p2 = s1_pidx - PT_W'(cols);
  assign p1 = p2 - PT_W'(1);
  assign p4 = s1_pidx - PT_W'(1);

  assign s1_adv = s1_valid && ((m1 == '0) || s2_free);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      tri_cnt    <= '0;
      left_pv    <= 1'b0;
      upper_left <= 1'b0;
      lf_ok      <= 1'b0;
      lf_tri     <= '0;
    end else if (s1_adv) begin
      tri_cnt    <= s1_frame_end ? '0 : s_val + TRI_W'(s_ok);
      left_pv    <= s1_pv;
      upper_left <= row_q;
      if (s1_cell) begin
        lf_ok  <= f_ok;
        lf_tri <= tri_cnt;
      end
    end
  end

  // result sequencer
  always_comb begin
    sel = SLOT_FIRST;
    for (int k = SLOT_NUM - 1; k >= 0; k--) begin
      if (s2.mask[k]) begin
        sel = SLOT_W'(k);
      end
    end
  end

  assign rest     = s2.mask & ~(SLOT_NUM'(1) << sel);
  assign load_out = (s2.mask != '0) && (!out_valid || out_ready);
  assign s2_free  = (s2.mask == '0) || (load_out && (rest == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.mask <= '0;
    end else if (s1_adv && (m1 != '0)) begin
      s2.mask <= m1;
    end else if (load_out) begin
      s2.mask <= rest;
    end
    if (s1_adv && (m1 != '0)) begin
      s2.f  <= tri_cnt;
      s2.s  <= s_val;
      s2.up <= tri_q[TRI_W-1:0];
      s2.lf <= lf_tri;
      s2.p1 <= p1;
      s2.p2 <= p2;
      s2.p3 <= s1_pidx;
      s2.p4 <= p4;
    end
  end

  always_comb begin
    kind_next       = KIND_TRI;
    tri_number_next = '0;
    vertex_a_next   = '0;
    vertex_b_next   = '0;
    vertex_c_next   = '0;
    edge_a_next     = '0;
    edge_b_next     = '0;
    case (sel)
      SLOT_FIRST: begin
        tri_number_next = s2.f;
        vertex_a_next   = s2.p1;
        vertex_b_next   = s2.p2;
        vertex_c_next   = s2.p3;
      end
      SLOT_SECOND: begin
        tri_number_next = s2.s;
        vertex_a_next   = s2.p3;
        vertex_b_next   = s2.p4;
        vertex_c_next   = s2.p1;
      end
      SLOT_DIAG: begin
        kind_next   = KIND_PAIR;
        edge_a_next = edge_num(s2.f, EDGE_2);
        edge_b_next = edge_num(s2.s, EDGE_2);
      end
      SLOT_TOP: begin
        kind_next   = KIND_PAIR;
        edge_a_next = edge_num(s2.f, EDGE_0);
        edge_b_next = edge_num(s2.up, EDGE_0);
      end
      SLOT_LEFT: begin
        kind_next   = KIND_PAIR;
        edge_a_next = edge_num(s2.s, EDGE_1);
        edge_b_next = edge_num(s2.lf, EDGE_1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind       <= kind_next;
      tri_number <= tri_number_next;
      vertex_a   <= vertex_a_next;
      vertex_b   <= vertex_b_next;
      vertex_c   <= vertex_c_next;
      edge_a     <= edge_a_next;
      edge_b     <= edge_b_next;
      last       <= rest == '0;
    end
  end

endmodule

`default_nettype wire

### dv/tb_grid_mesh_halfedge_builder.sv
// testbench for grid_mesh_halfedge_builder: grid triangles and half-edge twins against a model
`timescale 1ns / 100ps

module tb_grid_mesh_halfedge_builder;
  import gmhb_pkg::*;

  localparam int GRID_MAX_COLS  = 1024;
  localparam int GRID_MAX_ROWS  = 1024;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic              kind;
    logic [TRI_W-1:0]  tri_number;
    logic [PT_W-1:0]   vertex_a;
    logic [PT_W-1:0]   vertex_b;
    logic [PT_W-1:0]   vertex_c;
    logic [EDGE_W-1:0] edge_a;
    logic [EDGE_W-1:0] edge_b;
    logic              last;
  } mesh_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              point_valid = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              kind;
  logic [TRI_W-1:0]  tri_number;
  logic [PT_W-1:0]   vertex_a;
  logic [PT_W-1:0]   vertex_b;
  logic [PT_W-1:0]   vertex_c;
  logic [EDGE_W-1:0] edge_a;
  logic [EDGE_W-1:0] edge_b;
  logic              last;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_COLS;
  logic [DIM_W-1:0]  cfg_data = '0;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int error_count = 0;
  int stall_cycles = 0;

  mesh_result_t expected_mesh[$];

  // model state
  logic [DIM_W-1:0] m_cols_reg = DIM_W'(2);
  logic [DIM_W-1:0] m_rows_reg = DIM_W'(2);
  logic             m_upper_valid [GRID_MAX_COLS];
  logic [TRI_W-1:0] m_upper_tri [GRID_MAX_COLS];
  logic             m_upper_ok [GRID_MAX_COLS];
  logic             m_left_valid = 1'b0;
  logic [TRI_W-1:0] m_left_tri = '0;
  logic             m_left_ok = 1'b0;
  logic [TRI_W-1:0] m_tri_count = '0;
  int unsigned      m_row = 0;
  int unsigned      m_col = 0;

  grid_mesh_halfedge_builder #(
    .MAX_COLS(GRID_MAX_COLS),
    .MAX_ROWS(GRID_MAX_ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .point_valid(point_valid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .tri_number(tri_number),
    .vertex_a(vertex_a),
    .vertex_b(vertex_b),
    .vertex_c(vertex_c),
    .edge_a(edge_a),
    .edge_b(edge_b),
    .last(last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic mesh_result_t tri_result(input logic [TRI_W-1:0] t,
                                              input logic [PT_W-1:0] a,
                                              input logic [PT_W-1:0] b,
                                              input logic [PT_W-1:0] c);
    mesh_result_t r;
    r = '0;
    r.kind = KIND_TRI;
    r.tri_number = t;
    r.vertex_a = a;
    r.vertex_b = b;
    r.vertex_c = c;
    return r;
  endfunction

  function automatic mesh_result_t pair_result(input logic [EDGE_W-1:0] ea,
                                               input logic [EDGE_W-1:0] eb);
    mesh_result_t r;
    r = '0;
    r.kind = KIND_PAIR;
    r.edge_a = ea;
    r.edge_b = eb;
    return r;
  endfunction

  function automatic void queue_expected(input mesh_result_t r);
    expected_mesh.insert(expected_mesh.size(), r);
  endfunction

  // triangles and twin pairs completed by one grid point
  function automatic void predict_mesh_results(input logic pv);
    int unsigned g, nr, r, c, i, j;
    int n;
    logic [PT_W-1:0] p1, p2, p3, p4;
    logic v1, v2, v4, f_ok, s_ok;
    logic [TRI_W-1:0] f, s;
    mesh_result_t res [SLOT_NUM];
    n = 0;
    g = clamp_dim(m_cols_reg, GRID_MAX_COLS);
    nr = clamp_dim(m_rows_reg, GRID_MAX_ROWS);
    r = m_row;
    c = m_col;
    if (c >= g) c = 0;
    if (r >= nr) r = 0;
    if (r >= 1 && c >= 1) begin
      i = r - 1;
      j = c - 1;
      p1 = PT_W'(i * g + j);
      p2 = PT_W'(i * g + j + 1);
      p3 = PT_W'(r * g + c);
      p4 = PT_W'(r * g + j);
      v1 = m_upper_valid[j];
      v2 = m_upper_valid[c];
      v4 = m_left_valid;
      f_ok = v1 && v2 && pv;
      s_ok = pv && v4 && v1;
      f = '0;
      s = '0;
      if (f_ok) begin
        f = m_tri_count;
        res[n] = tri_result(f, p1, p2, p3);
        n++;
        m_tri_count = m_tri_count + 1'b1;
      end
      if (s_ok) begin
        s = m_tri_count;
        res[n] = tri_result(s, p3, p4, p1);
        n++;
        m_tri_count = m_tri_count + 1'b1;
      end
      if (f_ok && s_ok) begin
        res[n] = pair_result(EDGE_W'(3 * f + EDGE_2), EDGE_W'(3 * s + EDGE_2));
        n++;
      end
      if (f_ok && i > 0 && m_upper_ok[j]) begin
        res[n] = pair_result(EDGE_W'(3 * f + EDGE_0), EDGE_W'(3 * m_upper_tri[j] + EDGE_0));
        n++;
      end
      if (s_ok && j > 0 && m_left_ok) begin
        res[n] = pair_result(EDGE_W'(3 * s + EDGE_1), EDGE_W'(3 * m_left_tri + EDGE_1));
        n++;
      end
      m_upper_tri[j] = s;
      m_upper_ok[j] = s_ok;
      m_left_tri = f;
      m_left_ok = f_ok;
    end
    // line buffer is rewritten one point late
    if (c >= 1) m_upper_valid[c - 1] = m_left_valid;
    if (c == g - 1) m_upper_valid[c] = pv;
    m_left_valid = pv;
    c++;
    if (c >= g) begin
      c = 0;
      r++;
      if (r >= nr) begin
        r = 0;
        m_tri_count = '0;
      end
    end
    m_col = c;
    m_row = r;
    if (n > 0) res[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) queue_expected(res[k]);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_point(input logic pv);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_valid <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_mesh_results(pv);
  endtask

  // hold off the sender until every expected result has been seen
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_mesh.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(input logic idx, input logic [DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLS) m_cols_reg = val;
    else m_rows_reg = val;
    m_left_valid = 1'b0;
    m_left_tri = '0;
    m_left_ok = 1'b0;
    m_tri_count = '0;
    m_row = 0;
    m_col = 0;
    @(posedge clk);
  endtask

  task automatic send_pattern(input logic [23:0] pat, input int count);
    for (int k = count - 1; k >= 0; k--) send_point(pat[k]);
  endtask

  task automatic test_default_grid();
    // full cell, then missing top-right, then missing bottom-right
    send_pattern(24'b1111_1011_1110, 12);
  endtask

  task automatic test_cell_pairs();
    wait_idle();
    write_dim(CFG_COLS, DIM_W'(3));
    write_dim(CFG_ROWS, DIM_W'(3));
    send_pattern(24'b111_111_111, 9);
  endtask

  task automatic test_low_clamp();
    wait_idle();
    write_dim(CFG_COLS, DIM_W'(0));
    write_dim(CFG_ROWS, DIM_W'(1));
    send_pattern(24'b1111, 4);
  endtask

  task automatic test_random_frames(input int src_pct, input int sink_pct, input int budget);
    int sent, pts, density;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < budget) begin
      wait_idle();
      write_dim(CFG_COLS, DIM_W'($urandom_range(0, 14)));
      if ($urandom_range(3) != 0) write_dim(CFG_ROWS, DIM_W'($urandom_range(0, 7)));
      pts = clamp_dim(m_cols_reg, GRID_MAX_COLS) * clamp_dim(m_rows_reg, GRID_MAX_ROWS);
      pts = pts * $urandom_range(1, 2) + $urandom_range(0, 4);
      case ($urandom_range(3))
        0: density = 50;
        1: density = 90;
        default: density = 100;
      endcase
      repeat (pts) send_point($urandom_range(99) < density);
      sent += pts;
    end
  endtask

  task automatic test_wide_row();
    wait_idle();
    write_dim(CFG_COLS, {DIM_W{1'b1}});
    write_dim(CFG_ROWS, {DIM_W{1'b1}});
    repeat (40) send_point($urandom_range(99) < 90);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    mesh_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_mesh.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
      end else begin
        want = expected_mesh.pop_front();
        if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
        if (tri_number !== want.tri_number)
          report_mismatch("tri_number", tri_number, want.tri_number);
        if (vertex_a !== want.vertex_a) report_mismatch("vertex_a", vertex_a, want.vertex_a);
        if (vertex_b !== want.vertex_b) report_mismatch("vertex_b", vertex_b, want.vertex_b);
        if (vertex_c !== want.vertex_c) report_mismatch("vertex_c", vertex_c, want.vertex_c);
        if (edge_a !== want.edge_a) report_mismatch("edge_a", edge_a, want.edge_a);
        if (edge_b !== want.edge_b) report_mismatch("edge_b", edge_b, want.edge_b);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // no transfer on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct = 17;
    sink_idle_pct = 81;
    test_default_grid();
    test_cell_pairs();
    test_low_clamp();
    test_random_frames(17, 81, 110);
    test_random_frames(81, 17, 110);
    test_random_frames(0, 0, 110);
    test_wide_row();
    wait_idle();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
